// ----- rtl/mmh3_pkg.sv -----
// Shared types and constants for the 32-bit murmur hash block.
`timescale 1ns / 1ps
package mmh3_pkg;

  // Word mix, round and finaliser constants
  localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2 = 32'h1b873593;
  localparam logic [15:0] ADD_LO = 16'h6b64;
  localparam logic [15:0] ADD_HI = 16'he654;
  localparam logic [31:0] ADD_C  = {ADD_HI, ADD_LO};
  localparam logic [31:0] FIN_C1 = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2 = 32'hc2b2ae35;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_ROUND,
    ST_FIN1,
    ST_FIN2
  } state_t;

  // Datapath step commands
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_MIX1,
    STEP_MIX2,
    STEP_ROUND,
    STEP_FIN1,
    STEP_FIN2
  } step_t;

  // How the current word enters the running hash
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_TAIL,
    MODE_FULL
  } mode_t;

  typedef struct packed {
    logic  start;
    step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic key_active;
  } dp_status_t;

endpackage

// ----- rtl/mmh3_datapath.sv -----
// Datapath: seed, running hash, byte count, shared multiplier and result register.
`timescale 1ns / 1ps
module mmh3_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_seed_value,
  input  logic [31:0]         in_data_word,
  input  logic [2:0]          in_valid_bytes,
  input  logic                in_last_word,
  input  mmh3_pkg::dp_cmd_t   cmd,
  output mmh3_pkg::dp_status_t status,
  output logic [31:0]         out_hash_value
);
  import mmh3_pkg::*;

  logic [31:0] seed_r,  seed_nxt;
  logic        kip_r,   kip_nxt;
  logic [31:0] hash_r,  hash_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] work_r,  work_nxt;
  mode_t       mode_r,  mode_nxt;
  logic [2:0]  add_r,   add_nxt;
  logic        last_r,  last_nxt;
  logic [31:0] res_r,   res_nxt;

  logic        in_full;
  logic [31:0] in_mask;
  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] h_x, h_rot, h_full, h_round, c_round, fin0;

  // Byte mask for a short last word
  always_comb begin
    case (in_valid_bytes[1:0])
      2'd1:    in_mask = 32'h0000_00ff;
      2'd2:    in_mask = 32'h0000_ffff;
      2'd3:    in_mask = 32'h00ff_ffff;
      default: in_mask = 32'hffff_ffff;
    endcase
  end

  assign in_full = !in_last_word || (in_valid_bytes >= 3'd4);

  // Shared multiplier, operands picked by the current step
  always_comb begin
    case (cmd.step)
      STEP_MIX1: begin
        mul_a = work_r;
        mul_b = MIX_C1;
      end
      STEP_MIX2: begin
        mul_a = {work_r[16:0], work_r[31:17]};
        mul_b = MIX_C2;
      end
      STEP_FIN1: begin
        mul_a = work_r;
        mul_b = FIN_C1;
      end
      STEP_FIN2: begin
        mul_a = work_r;
        mul_b = FIN_C2;
      end
      default: begin
        mul_a = work_r;
        mul_b = 32'd0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Hash round: rotate by 13, times five, add
  assign h_x    = hash_r ^ work_r;
  assign h_rot  = {h_x[18:0], h_x[31:19]};
  assign h_full = h_rot + {h_rot[29:0], 2'b00} + ADD_C;

  always_comb begin
    case (mode_r)
      MODE_FULL: h_round = h_full;
      MODE_TAIL: h_round = h_x;
      default:   h_round = hash_r;
    endcase
  end

  assign c_round = count_r + {29'd0, add_r};
  assign fin0    = h_round ^ c_round;

  // Next-state logic
  always_comb begin
    seed_nxt  = cfg_we ? cfg_seed_value : seed_r;
    kip_nxt   = kip_r;
    hash_nxt  = hash_r;
    count_nxt = count_r;
    work_nxt  = work_r;
    mode_nxt  = mode_r;
    add_nxt   = add_r;
    last_nxt  = last_r;
    res_nxt   = res_r;

    if (cmd.start) begin
      kip_nxt   = 1'b1;
      hash_nxt  = kip_r ? hash_r  : seed_r;
      count_nxt = kip_r ? count_r : 32'd0;
      work_nxt  = in_full ? in_data_word : (in_data_word & in_mask);
      last_nxt  = in_last_word;
      add_nxt   = in_full ? 3'd4 : in_valid_bytes;
      if (in_full) begin
        mode_nxt = MODE_FULL;
      end else if (in_valid_bytes != 3'd0) begin
        mode_nxt = MODE_TAIL;
      end else begin
        mode_nxt = MODE_NONE;
      end
    end

    case (cmd.step)
      STEP_MIX1, STEP_MIX2: begin
        work_nxt = prod;
      end
      STEP_ROUND: begin
        hash_nxt  = h_round;
        count_nxt = c_round;
        work_nxt  = fin0 ^ {16'd0, fin0[31:16]};
        if (last_r) begin
          kip_nxt = 1'b0;
        end
      end
      STEP_FIN1: begin
        work_nxt = prod ^ {13'd0, prod[31:13]};
      end
      STEP_FIN2: begin
        res_nxt = prod ^ {16'd0, prod[31:16]};
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
      kip_r  <= 1'b0;
    end else begin
      seed_r <= seed_nxt;
      kip_r  <= kip_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hash_r  <= hash_nxt;
    count_r <= count_nxt;
    work_r  <= work_nxt;
    mode_r  <= mode_nxt;
    add_r   <= add_nxt;
    last_r  <= last_nxt;
    res_r   <= res_nxt;
  end

  assign status.last       = last_r;
  assign status.key_active = kip_r;
  assign out_hash_value    = res_r;

endmodule

// ----- rtl/mmh3_ctrl.sv -----
// Controller: sequences mix, round and finaliser steps and owns the handshakes.
`timescale 1ns / 1ps
module mmh3_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  mmh3_pkg::dp_status_t status,
  output mmh3_pkg::dp_cmd_t    cmd
);
  import mmh3_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.start     = 1'b0;
    cmd.step      = STEP_NONE;
    in_stall      = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_MIX1;
        end
      end
      ST_MIX1: begin
        cmd.step  = STEP_MIX1;
        state_nxt = ST_MIX2;
      end
      ST_MIX2: begin
        cmd.step  = STEP_MIX2;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.step  = STEP_ROUND;
        state_nxt = status.last ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1: begin
        cmd.step  = STEP_FIN1;
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        // wait here until the result register is free
        if (out_free) begin
          cmd.step      = STEP_FIN2;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  // a finished hash always shows up as a valid result
  a_fin_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step == STEP_FIN2 |=> out_valid_r)
    else $error("finaliser result not presented");

  // the finaliser never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step == STEP_FIN2 |-> out_free)
    else $error("result register overwritten");

  // a key word that is not the last frees the input after its round
  a_round_release: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND && !status.last |=> state_r == ST_IDLE)
    else $error("non-final word did not release input");

  // every transfer in leaves a key open and moves on to the first mix step
  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> status.key_active && state_r == ST_MIX1)
    else $error("accepted word did not start processing");
`endif

endmodule

// ----- rtl/murmur3_32_hash.sv -----
// Top level of the streaming 32-bit murmur hash (x86_32 variant).
//
// Input channel: in_data_word (little-endian, first byte in bits 7:0),
// in_valid_bytes and in_last_word, with in_valid / in_stall. A word that is
// not the last counts as four bytes. A last word with zero valid bytes ends
// the key without mixing, so an empty key gives the hash of the seed alone.
// Output channel: out_hash_value with out_valid / out_stall, one transfer per
// key, issued for the last word.
// Configuration: cfg_seed_value with cfg_valid / cfg_ready (always ready); the
// seed is picked up when the first word of a key is taken.
// Sequencing: a word is taken, then goes through two multiply steps on the
// single shared 32x32 multiplier and a hash round before the next is taken; a
// last word adds two finaliser multiply steps, after which the hash is valid.
// The result sits in an output register, so the next key's words are taken
// while the receiver stalls; only a further last word waits in the final
// multiply step until that register is free.
// Reset (rst_n low, synchronous) clears the seed to zero, drops any key in
// progress and any pending result.
`timescale 1ns / 1ps
module murmur3_32_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_seed_value,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);
  import mmh3_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_we;

  // Seed register is always ready and takes a write whenever cfg_valid is high
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  mmh3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mmh3_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_seed_value (cfg_seed_value),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last_word   (in_last_word),
    .cmd            (cmd),
    .status         (status),
    .out_hash_value (out_hash_value)
  );

endmodule
